### src/ide_pkg.sv
// Shared types and constants for the indexed deque engine.
package ide_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int WORD_WIDTH_DEF = 32;

   localparam int MODE_W = 4;
   localparam int DATA_W = 32;
   localparam int POS_W  = 7;
   localparam int STAT_W = 3;
   localparam int OPOS_W = 6;
   localparam int FILL_W = 7;

   typedef enum logic [MODE_W-1:0] {
      OP_PUSH_BACK  = 4'd0,
      OP_PUSH_FRONT = 4'd1,
      OP_POP_BACK   = 4'd2,
      OP_POP_FRONT  = 4'd3,
      OP_INSERT     = 4'd4,
      OP_READ       = 4'd5,
      OP_FIND       = 4'd6,
      OP_FIND_FWD   = 4'd7,
      OP_FIND_BACK  = 4'd8,
      OP_CMP_AT     = 4'd9,
      OP_CMP_LAST   = 4'd10
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_FULL     = 3'd2,
      ST_RANGE    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_WAIT,
      S_WALK,
      S_SHIFT,
      S_WRITE,
      S_DONE
   } state_type;

endpackage

### src/ide_store.sv
// Slot memory: one write port, one registered read port.
module ide_store #(
   parameter int CAPACITY   = ide_pkg::CAPACITY_DEF,
   parameter int WORD_WIDTH = ide_pkg::WORD_WIDTH_DEF,
   localparam int AW = $clog2(CAPACITY)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [WORD_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [WORD_WIDTH-1:0] rd_data
);
   logic [WORD_WIDTH-1:0] mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### src/indexed_deque_engine_top.sv
// Indexed deque engine: top level with sequencer, walk counter and result register.
//
//  channel | dir | tdata fields (low bit up)                       | tuser
//  req     | in  | mode[3:0], data_value[35:4], position[42:36]    | -
//  rsp     | out | status[2:0], out_value[34:3], out_position[40:35],
//          |     | fill_level[47:41], match[48]                    | -
//
// One request at a time. A push passes S_RD and S_WRITE before its result shows; a pop,
// read or compare passes S_RD, S_WAIT and S_WALK.
// Insert walks the tail down to the position, reading then writing each moved element
// through the single memory port pair.
// Searches compare one slot at a time (address in S_WAIT, registered read checked in S_WALK)
// against a single comparator.
// Reset is synchronous and clears head and count; slot
// contents stay undefined. A result waits in rsp until taken; req_tready
// stays low until then.
module indexed_deque_engine_top #(
   parameter int CAPACITY   = ide_pkg::CAPACITY_DEF,
   parameter int WORD_WIDTH = ide_pkg::WORD_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // mode, data_value, position
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // status, out_value, out_position, fill_level, match
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = CW + 1;

   ide_pkg::state_type state_ff, state_in;
   logic [ide_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [WORD_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0] pos_ff, pos_in;      // request position, clipped
   logic          pos_big_ff, pos_big_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] idx_ff, idx_in;      // walk index
   logic [ide_pkg::STAT_W-1:0] st_ff, st_in;
   logic [WORD_WIDTH-1:0] oval_ff, oval_in;
   logic [CW-1:0] opos_ff, opos_in;
   logic          m_ff, m_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [WORD_WIDTH-1:0] wr_data, rd_data;
   logic          full, empty, pos_ge, pos_gt, hit;

   ide_store #(.CAPACITY(CAPACITY), .WORD_WIDTH(WORD_WIDTH)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   // ring slot of element i; one conditional subtract wraps it
   function automatic logic [AW-1:0] ring(input logic [AW-1:0] h, input logic [CW-1:0] i);
      logic [CW:0] s;
      s = {1'b0, i} + {{(CW+1-AW){1'b0}}, h};
      if (s >= SW'(CAPACITY)) s = s - SW'(CAPACITY);
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] head_next(input logic [AW-1:0] h);
      return (h == AW'(CAPACITY - 1)) ? '0 : h + 1'b1;
   endfunction

   function automatic logic [AW-1:0] head_prev(input logic [AW-1:0] h);
      return (h == '0) ? AW'(CAPACITY - 1) : h - 1'b1;
   endfunction

   assign full   = (cnt_ff == CW'(CAPACITY));
   assign empty  = (cnt_ff == '0);
   assign pos_ge = pos_big_ff || (pos_ff >= cnt_ff);
   assign pos_gt = pos_big_ff || (pos_ff > cnt_ff);
   assign hit    = (rd_data == val_ff);
   assign req_tready = (state_ff == ide_pkg::S_IDLE);

   // next state and datapath
   always_comb begin
      state_in = state_ff; mode_in = mode_ff; val_in = val_ff;
      pos_in = pos_ff; pos_big_in = pos_big_ff; cnt_in = cnt_ff; head_in = head_ff;
      idx_in = idx_ff; st_in = st_ff; oval_in = oval_ff; opos_in = opos_ff; m_in = m_ff;
      unique case (state_ff)
         ide_pkg::S_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tdata[3:0];
               val_in  = WORD_WIDTH'(req_tdata[35:4]);
               if (CW >= 7) begin
                  pos_in = CW'(req_tdata[42:36]); pos_big_in = 1'b0;
               end else begin
                  pos_in = req_tdata[36 +: CW];
                  pos_big_in = (req_tdata[42:36] >> CW) != 0;
               end
               state_in = ide_pkg::S_RD;
            end
         end
         ide_pkg::S_RD: begin
            st_in = ide_pkg::ST_OK; oval_in = '0; opos_in = '0; m_in = 1'b0;
            state_in = ide_pkg::S_DONE;
            unique case (mode_ff)
               ide_pkg::OP_PUSH_BACK: if (full) st_in = ide_pkg::ST_FULL;
                  else begin opos_in = cnt_ff; state_in = ide_pkg::S_WRITE; end
               ide_pkg::OP_PUSH_FRONT: if (full) st_in = ide_pkg::ST_FULL;
                  else state_in = ide_pkg::S_WRITE;
               ide_pkg::OP_POP_BACK, ide_pkg::OP_POP_FRONT, ide_pkg::OP_CMP_LAST:
                  if (empty) begin
                     if (mode_ff != ide_pkg::OP_CMP_LAST) st_in = ide_pkg::ST_EMPTY;
                  end else begin
                     idx_in = (mode_ff == ide_pkg::OP_POP_FRONT) ? '0 : cnt_ff - 1'b1;
                     state_in = ide_pkg::S_WAIT;
                  end
               ide_pkg::OP_INSERT: if (pos_gt) st_in = ide_pkg::ST_RANGE;
                  else if (full) st_in = ide_pkg::ST_FULL;
                  else begin idx_in = cnt_ff; state_in = ide_pkg::S_SHIFT; end
               ide_pkg::OP_READ, ide_pkg::OP_CMP_AT: if (pos_ge) st_in = ide_pkg::ST_RANGE;
                  else begin idx_in = pos_ff; state_in = ide_pkg::S_WAIT; end
               ide_pkg::OP_FIND, ide_pkg::OP_FIND_FWD, ide_pkg::OP_FIND_BACK:
                  if (empty) st_in = ide_pkg::ST_NOTFOUND;
                  else if (mode_ff != ide_pkg::OP_FIND && pos_ge) st_in = ide_pkg::ST_RANGE;
                  else begin
                     idx_in = (mode_ff == ide_pkg::OP_FIND) ? '0 : pos_ff;
                     st_in = ide_pkg::ST_NOTFOUND;
                     state_in = ide_pkg::S_WAIT;
                  end
               default: ;
            endcase
         end
         ide_pkg::S_WAIT: state_in = ide_pkg::S_WALK;
         ide_pkg::S_WALK: begin
            state_in = ide_pkg::S_DONE;
            unique case (mode_ff)
               ide_pkg::OP_POP_BACK: begin
                  oval_in = rd_data; opos_in = idx_ff; cnt_in = cnt_ff - 1'b1;
               end
               ide_pkg::OP_POP_FRONT: begin
                  oval_in = rd_data; head_in = head_next(head_ff); cnt_in = cnt_ff - 1'b1;
               end
               ide_pkg::OP_READ: begin oval_in = rd_data; opos_in = idx_ff; end
               ide_pkg::OP_CMP_AT, ide_pkg::OP_CMP_LAST: begin
                  m_in = hit; opos_in = idx_ff;
               end
               ide_pkg::OP_FIND_BACK:
                  if (hit) begin st_in = ide_pkg::ST_OK; opos_in = idx_ff; end
                  else if (idx_ff != '0) begin
                     idx_in = idx_ff - 1'b1; state_in = ide_pkg::S_WAIT;
                  end
               default:
                  if (hit) begin st_in = ide_pkg::ST_OK; opos_in = idx_ff; end
                  else if (idx_ff + 1'b1 != cnt_ff) begin
                     idx_in = idx_ff + 1'b1; state_in = ide_pkg::S_WAIT;
                  end
            endcase
         end
         ide_pkg::S_SHIFT: begin
            // rd_data holds slot idx-1 after the read phase with m clear; alternate via the m bit
            if (idx_ff == pos_ff) state_in = ide_pkg::S_WRITE;
            else if (m_ff) begin
               m_in = 1'b0; idx_in = idx_ff - 1'b1;
            end else m_in = 1'b1;
         end
         ide_pkg::S_WRITE: begin
            cnt_in = cnt_ff + 1'b1;
            if (mode_ff == ide_pkg::OP_PUSH_FRONT) head_in = head_prev(head_ff);
            if (mode_ff == ide_pkg::OP_INSERT) begin opos_in = pos_ff; m_in = 1'b0; end
            state_in = ide_pkg::S_DONE;
         end
         ide_pkg::S_DONE: if (rsp_tready) state_in = ide_pkg::S_IDLE;
         default: state_in = ide_pkg::S_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      rd_addr = ring(head_ff, idx_ff);
      wr_en   = 1'b0;
      wr_addr = ring(head_ff, idx_ff);
      wr_data = rd_data;
      if (state_ff == ide_pkg::S_SHIFT) begin
         rd_addr = ring(head_ff, idx_ff - 1'b1);
         wr_en   = m_ff && (idx_ff != pos_ff);
      end else if (state_ff == ide_pkg::S_WRITE) begin
         wr_en   = 1'b1;
         wr_data = val_ff;
         unique case (mode_ff)
            ide_pkg::OP_PUSH_BACK:  wr_addr = ring(head_ff, cnt_ff);
            ide_pkg::OP_PUSH_FRONT: wr_addr = head_prev(head_ff);
            default:                wr_addr = ring(head_ff, pos_ff);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ide_pkg::S_IDLE;
         cnt_ff   <= '0;
         head_ff  <= '0;
         m_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         head_ff  <= head_in;
         m_ff     <= m_in;
      end
      mode_ff <= mode_in; val_ff <= val_in; pos_ff <= pos_in; pos_big_ff <= pos_big_in;
      idx_ff <= idx_in; st_ff <= st_in; oval_ff <= oval_in; opos_ff <= opos_in;
   end

   assign rsp_tvalid = (state_ff == ide_pkg::S_DONE);
   assign rsp_tdata  = {7'd0, m_ff, 7'(cnt_ff), 6'(opos_ff), 32'(oval_ff), st_ff};
endmodule

### src/ide_checker.sv
// Port-level checks for the indexed deque engine, bound to the top level.
module ide_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after accept");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:41] <= 7'd64) else $error("fill overflow");
endmodule

bind indexed_deque_engine_top ide_checker u_ide_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the indexed deque engine: directed and random requests.
module tb_top;

   localparam int CAP       = 64;
   localparam int WDOG_MAX  = 4000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // mode[3:0], data_value[35:4], position[42:36]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // status[2:0], out_value[34:3], out_position[40:35],
                             // fill_level[47:41], match[48]

   // first member is the top bits: match down to status
   typedef struct packed {
      logic        match;
      logic [6:0]  fill;
      logic [5:0]  opos;
      logic [31:0] value;
      logic [2:0]  status;
   } deque_result_type;

   indexed_deque_engine_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 12-unit clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // shadow deque state
   logic [31:0]   shadow_slots[CAP];
   int unsigned   shadow_head;
   int unsigned   shadow_count;
   deque_result_type expected_q[$];
   int            error_count;
   int            idle_cycles;
   bit            allow_stall;

   function automatic int unsigned ring(int unsigned i);
      return (shadow_head + i) % CAP;
   endfunction

   // Apply one request to the shadow state and return the expected response.
   function automatic deque_result_type deque_apply(logic [3:0] mode, logic [31:0] v,
                                                    logic [6:0] pos);
      deque_result_type r;
      int unsigned   p;
      int            i;
      p = 32'(pos);
      r = '0;
      r.status = ide_pkg::ST_OK;
      case (mode)
         ide_pkg::OP_PUSH_BACK: begin
            if (shadow_count >= CAP) r.status = ide_pkg::ST_FULL;
            else begin
               shadow_slots[ring(shadow_count)] = v;
               r.opos = 6'(shadow_count);
               shadow_count++;
            end
         end
         ide_pkg::OP_PUSH_FRONT: begin
            if (shadow_count >= CAP) r.status = ide_pkg::ST_FULL;
            else begin
               shadow_head = (shadow_head + CAP - 1) % CAP;
               shadow_slots[shadow_head] = v;
               shadow_count++;
            end
         end
         ide_pkg::OP_POP_BACK: begin
            if (shadow_count == 0) r.status = ide_pkg::ST_EMPTY;
            else begin
               shadow_count--;
               r.value = shadow_slots[ring(shadow_count)];
               r.opos  = 6'(shadow_count);
            end
         end
         ide_pkg::OP_POP_FRONT: begin
            if (shadow_count == 0) r.status = ide_pkg::ST_EMPTY;
            else begin
               r.value = shadow_slots[shadow_head];
               shadow_head = (shadow_head + 1) % CAP;
               shadow_count--;
            end
         end
         ide_pkg::OP_INSERT: begin
            // range is checked before fullness
            if (p > shadow_count) r.status = ide_pkg::ST_RANGE;
            else if (shadow_count >= CAP) r.status = ide_pkg::ST_FULL;
            else begin
               for (i = int'(shadow_count); i > int'(p); i--)
                  shadow_slots[ring(i)] = shadow_slots[ring(i - 1)];
               shadow_slots[ring(p)] = v;
               shadow_count++;
               r.opos = 6'(p);
            end
         end
         ide_pkg::OP_READ: begin
            if (p >= shadow_count) r.status = ide_pkg::ST_RANGE;
            else begin
               r.value = shadow_slots[ring(p)];
               r.opos  = 6'(p);
            end
         end
         ide_pkg::OP_FIND, ide_pkg::OP_FIND_FWD: begin
            if (shadow_count == 0) r.status = ide_pkg::ST_NOTFOUND;
            else if (mode == ide_pkg::OP_FIND_FWD && p >= shadow_count)
               r.status = ide_pkg::ST_RANGE;
            else begin
               r.status = ide_pkg::ST_NOTFOUND;
               for (i = (mode == ide_pkg::OP_FIND_FWD) ? int'(p) : 0;
                    i < int'(shadow_count); i++)
                  if (shadow_slots[ring(i)] == v) begin
                     r.status = ide_pkg::ST_OK;
                     r.opos   = 6'(i);
                     break;
                  end
            end
         end
         ide_pkg::OP_FIND_BACK: begin
            if (shadow_count == 0) r.status = ide_pkg::ST_NOTFOUND;
            else if (p >= shadow_count) r.status = ide_pkg::ST_RANGE;
            else begin
               r.status = ide_pkg::ST_NOTFOUND;
               for (i = int'(p); i >= 0; i--)
                  if (shadow_slots[ring(i)] == v) begin
                     r.status = ide_pkg::ST_OK;
                     r.opos   = 6'(i);
                     break;
                  end
            end
         end
         ide_pkg::OP_CMP_AT: begin
            if (p >= shadow_count) r.status = ide_pkg::ST_RANGE;
            else begin
               r.match = (shadow_slots[ring(p)] == v);
               r.opos  = 6'(p);
            end
         end
         ide_pkg::OP_CMP_LAST: begin
            // empty list: ok with no match
            if (shadow_count != 0) begin
               r.opos  = 6'(shadow_count - 1);
               r.match = (shadow_slots[ring(shadow_count - 1)] == v);
            end
         end
         default: ;
      endcase
      r.fill = 7'(shadow_count);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
      $display("mismatch %s: got %0h expected %0h", what, got, exp);
      error_count++;
   endtask

   // tvalid stays high after an accept; within a run of requests it drops only for an idle burst
   task automatic send_request(logic [3:0] mode, logic [31:0] v, logic [6:0] pos);
      int gap;
      if (allow_stall && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, pos, v, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(deque_apply(mode, v, pos));
   endtask

   // value likely to be present when the list is nonempty
   function automatic logic [31:0] pick_value();
      if (shadow_count != 0 && $urandom_range(0, 2) != 0)
         return shadow_slots[ring($urandom_range(0, shadow_count - 1))];
      return $urandom_range(0, 7);
   endfunction

   function automatic logic [6:0] pick_pos();
      case ($urandom_range(0, 4))
         0:       return 7'(shadow_count);
         1:       return 7'($urandom_range(0, 127));
         default: return (shadow_count == 0) ? 7'd0 : 7'($urandom_range(0, shadow_count - 1));
      endcase
   endfunction

   // Response checker and receiver stalls
   always @(posedge clock) begin
      deque_result_type got, exp;
      if (reset) begin
         rsp_tready  <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[48:0];
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata[31:0], 32'd0);
            end else begin
               exp = expected_q.pop_front();
               if (got.status !== exp.status)
                  report_mismatch("status", 32'(got.status), 32'(exp.status));
               if (got.value !== exp.value) report_mismatch("out_value", got.value, exp.value);
               if (got.opos !== exp.opos)
                  report_mismatch("out_position", 32'(got.opos), 32'(exp.opos));
               if (got.fill !== exp.fill)
                  report_mismatch("fill_level", 32'(got.fill), 32'(exp.fill));
               if (got.match !== exp.match)
                  report_mismatch("match", 32'(got.match), 32'(exp.match));
            end
         end
         if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            rsp_tready  <= 1'b0;
         end else if (allow_stall && $urandom_range(0, 7) == 0) begin
            idle_cycles <= $urandom_range(1, 17) - 1;
            rsp_tready  <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WDOG_MAX) begin
         $display("[indexed_deque_engine_top] ERROR");
         $finish;
      end
   end

   // ---- test tasks ----

   // empty-list corner cases
   task automatic test_empty_list();
      send_request(ide_pkg::OP_POP_BACK, 32'h0, 7'd0);
      send_request(ide_pkg::OP_POP_FRONT, 32'h0, 7'd0);
      send_request(ide_pkg::OP_FIND, 32'h0, 7'd0);
      send_request(ide_pkg::OP_FIND_FWD, 32'h1, 7'd0);
      send_request(ide_pkg::OP_FIND_BACK, 32'h1, 7'd0);
      send_request(ide_pkg::OP_CMP_LAST, 32'h0, 7'd0);
      send_request(ide_pkg::OP_READ, 32'h0, 7'd0);
      send_request(4'd15, 32'hFFFF_FFFF, 7'h7F);
   endtask

   // every operation with extreme field values
   task automatic test_each_operation();
      send_request(ide_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, 7'd0);
      send_request(ide_pkg::OP_PUSH_FRONT, 32'h0, 7'h7F);
      send_request(ide_pkg::OP_INSERT, 32'hA5A5_5A5A, 7'd1);
      send_request(ide_pkg::OP_INSERT, 32'h1, 7'd5);      // past end
      send_request(ide_pkg::OP_READ, 32'h0, 7'd2);
      send_request(ide_pkg::OP_READ, 32'h0, 7'd3);        // past end
      send_request(ide_pkg::OP_FIND, 32'hFFFF_FFFF, 7'd0);
      send_request(ide_pkg::OP_FIND_FWD, 32'h0, 7'd1);
      send_request(ide_pkg::OP_FIND_FWD, 32'h0, 7'd64);
      send_request(ide_pkg::OP_FIND_BACK, 32'h0, 7'd2);
      send_request(ide_pkg::OP_FIND_BACK, 32'h7, 7'd2);   // no match
      send_request(ide_pkg::OP_CMP_AT, 32'hA5A5_5A5A, 7'd1);
      send_request(ide_pkg::OP_CMP_AT, 32'h0, 7'd9);
      send_request(ide_pkg::OP_CMP_LAST, 32'hFFFF_FFFF, 7'd0);
      send_request(ide_pkg::OP_POP_BACK, 32'h0, 7'd0);
      send_request(ide_pkg::OP_POP_FRONT, 32'h0, 7'd0);
   endtask

   // fill to capacity, push and insert into the full list, search it, then drain it
   task automatic test_full_list();
      while (shadow_count < CAP)
         send_request(ide_pkg::OP_PUSH_BACK, $urandom, 7'd0);
      send_request(ide_pkg::OP_PUSH_BACK, 32'h1, 7'd0);
      send_request(ide_pkg::OP_PUSH_FRONT, 32'h1, 7'd0);
      send_request(ide_pkg::OP_INSERT, 32'h1, 7'd0);
      send_request(ide_pkg::OP_INSERT, 32'h1, 7'd64);
      send_request(ide_pkg::OP_INSERT, 32'h1, 7'd65);
      send_request(ide_pkg::OP_FIND_BACK, 32'h0, 7'd63);
      while (shadow_count > 0)
         send_request($urandom_range(0, 1) ? ide_pkg::OP_POP_BACK : ide_pkg::OP_POP_FRONT,
                      32'h0, 7'd0);
   endtask

   // random mix, biased so the list stays mostly nonempty and values repeat
   task automatic test_random_mix(int n);
      logic [3:0] mode;
      int         k;
      for (k = 0; k < n; k++) begin
         if (k == n - 150) allow_stall = 1'b0;
         if (shadow_count < 4 && $urandom_range(0, 1)) mode = 4'($urandom_range(0, 1));
         else if ($urandom_range(0, 19) == 0) mode = 4'($urandom_range(11, 15));
         else if ($urandom_range(0, 5) == 0) mode = 4'($urandom_range(0, 4));
         else mode = 4'($urandom_range(0, 10));
         if ($urandom_range(0, 9) == 0)
            send_request(mode, $urandom, 7'($urandom_range(0, 127)));
         else
            send_request(mode, pick_value(), pick_pos());
      end
   endtask

   initial begin
      int waited;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      error_count = 0;
      allow_stall = 1'b1;
      shadow_head = 0;
      shadow_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_each_operation();
      test_full_list();
      test_random_mix(1000);
      req_tvalid <= 1'b0;

      waited = 0;
      while (expected_q.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (2 * CAP + 10) @(posedge clock);
      if (expected_q.size() != 0)
         report_mismatch("missing responses", 32'(expected_q.size()), 32'd0);
      if (error_count == 0) begin
         $display("[indexed_deque_engine_top] OK");
      end else begin
         $display("[indexed_deque_engine_top] ERROR");
      end
      $finish;
   end

endmodule
